@@ src/ssh_pkg.sv @@
`default_nettype none

package ssh_pkg;

   localparam int KEY_WIDTH      = 8;
   localparam int HASH_WIDTH     = 32;
   localparam int ALG_WIDTH      = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int DIV_COUNT_WIDTH = $clog2(HASH_WIDTH);

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALGORITHM    = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BUCKET_COUNT = 1'b1;

   // Hash algorithm codes.
   localparam logic [ALG_WIDTH-1:0] ALG_RS   = 3'd0;
   localparam logic [ALG_WIDTH-1:0] ALG_JS   = 3'd1;
   localparam logic [ALG_WIDTH-1:0] ALG_PJW  = 3'd2;
   localparam logic [ALG_WIDTH-1:0] ALG_ELF  = 3'd3;
   localparam logic [ALG_WIDTH-1:0] ALG_BKDR = 3'd4;
   localparam logic [ALG_WIDTH-1:0] ALG_SDBM = 3'd5;
   localparam logic [ALG_WIDTH-1:0] ALG_DJB  = 3'd6;
   localparam logic [ALG_WIDTH-1:0] ALG_AP   = 3'd7;

   localparam logic [HASH_WIDTH-1:0] RS_B_MULT     = 32'd378551;
   localparam logic [HASH_WIDTH-1:0] RS_A_SEED     = 32'd63689;
   localparam logic [HASH_WIDTH-1:0] JS_SEED       = 32'd1315423911;
   localparam logic [HASH_WIDTH-1:0] HIGH_NIBBLE   = 32'hF000_0000;
   localparam logic [HASH_WIDTH-1:0] BKDR_MULT     = 32'd131;
   localparam logic [HASH_WIDTH-1:0] DJB_SEED      = 32'd5381;
   localparam logic [HASH_WIDTH-1:0] BUCKET_RESET  = 32'd65536;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_UPDATE,
      ST_DIVIDE,
      ST_DELIVER
   } ssh_state_type;

   function automatic logic [HASH_WIDTH-1:0] ssh_seed(input logic [ALG_WIDTH-1:0] alg);
      logic [HASH_WIDTH-1:0] seed;
      seed = '0;
      if (alg == ALG_JS) begin
         seed = JS_SEED;
      end else if (alg == ALG_DJB) begin
         seed = DJB_SEED;
      end
      return seed;
   endfunction

endpackage

`default_nettype wire

@@ src/ssh_stream_if.sv @@
`default_nettype none

interface ssh_req_if;
   import ssh_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [KEY_WIDTH-1:0] key_byte;
   logic                 last_byte;

   modport source (output valid, output key_byte, output last_byte, input ready);
   modport sink (input valid, input key_byte, input last_byte, output ready);
endinterface

interface ssh_rsp_if;
   import ssh_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [HASH_WIDTH-1:0] bucket_index;

   modport source (output valid, output bucket_index, input ready);
   modport sink (input valid, input bucket_index, output ready);
endinterface

`default_nettype wire

@@ src/selectable_string_hasher.sv @@
// Hashes a key that arrives one byte per transfer on req_bus with one of eight 32-bit
// string hashes (RS, JS, PJW, ELF, BKDR, SDBM, DJB, AP), selected by the algorithm
// register; the byte marked last_byte yields bucket_index = hash mod bucket_count on
// rsp_bus (the raw hash when bucket_count is zero) and reloads the seeds for the next
// key. A byte passes from transfer to the next ready through accept, one pass through
// the shared 32x32 multiplier, and the hash update that also steps the RS multiplier
// through the same unit. A last byte then goes through the bit-serial remainder unit
// (skipped when bucket_count is zero) and a state that loads the output register,
// waiting while an earlier result is unaccepted. The output register lets the next key
// start while a result waits. Writing the algorithm register abandons any partial key.
`default_nettype none

module selectable_string_hasher (
   input  wire                                   clock,
   input  wire                                   reset,
   ssh_req_if.sink                               req_bus,
   ssh_rsp_if.source                             rsp_bus,
   input  wire                                   csr_write_enable,
   input  wire [ssh_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire [ssh_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data
);
   import ssh_pkg::*;

   ssh_state_type               state_ff, state_in;
   logic [ALG_WIDTH-1:0]        algorithm_ff, algorithm_in;
   logic [HASH_WIDTH-1:0]       bucket_ff, bucket_in;
   logic [HASH_WIDTH-1:0]       hash_ff, hash_in;
   logic [HASH_WIDTH-1:0]       rs_mult_ff, rs_mult_in;
   logic                        odd_ff, odd_in;
   logic [HASH_WIDTH-1:0]       char_ff, char_in;
   logic                        last_ff, last_in;
   logic [HASH_WIDTH-1:0]       prod_ff, prod_in;
   logic [HASH_WIDTH-1:0]       dividend_ff, dividend_in;
   logic [HASH_WIDTH-1:0]       rem_ff, rem_in;
   logic [DIV_COUNT_WIDTH-1:0]  count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [HASH_WIDTH-1:0]       rsp_index_ff, rsp_index_in;

   logic [HASH_WIDTH-1:0]       mul_a;
   logic [HASH_WIDTH-1:0]       mul_b;
   logic [HASH_WIDTH-1:0]       mul_product;
   logic [HASH_WIDTH-1:0]       hash_next;
   logic [HASH_WIDTH-1:0]       fold_sum;
   logic [HASH_WIDTH-1:0]       fold_top;
   logic [HASH_WIDTH:0]         div_shifted;
   logic [HASH_WIDTH:0]         div_diff;
   logic                        req_transfer;
   logic                        rsp_transfer;

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign req_transfer         = req_bus.valid && req_bus.ready;
   assign rsp_transfer         = rsp_valid_ff && rsp_bus.ready;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.bucket_index = rsp_index_ff;

   // The one multiplier serves the hash product in ST_MUL and steps the RS
   // multiplier in ST_UPDATE; only the low 32 bits are kept.
   always_comb begin
      if (state_ff == ST_MUL) begin
         mul_a = hash_ff;
         mul_b = (algorithm_ff == ALG_RS) ? rs_mult_ff : BKDR_MULT;
      end else begin
         mul_a = RS_B_MULT;
         mul_b = rs_mult_ff;
      end
   end

   assign mul_product = mul_a * mul_b;

   assign fold_sum = (hash_ff << 4) + char_ff;
   assign fold_top = fold_sum & HIGH_NIBBLE;

   always_comb begin
      case (algorithm_ff)
         ALG_RS: begin
            hash_next = prod_ff + char_ff;
         end
         ALG_JS: begin
            hash_next = hash_ff ^ ((hash_ff << 5) + char_ff + (hash_ff >> 2));
         end
         ALG_PJW, ALG_ELF: begin
            // Folding an empty top nibble changes nothing, so it is applied always.
            hash_next = (fold_sum ^ (fold_top >> 24)) & ~fold_top;
         end
         ALG_BKDR: begin
            hash_next = prod_ff + char_ff;
         end
         ALG_SDBM: begin
            hash_next = char_ff + (hash_ff << 6) + (hash_ff << 16) - hash_ff;
         end
         ALG_DJB: begin
            hash_next = hash_ff + (hash_ff << 5) + char_ff;
         end
         ALG_AP: begin
            if (!odd_ff) begin
               hash_next = hash_ff ^ ((hash_ff << 7) ^ char_ff ^ (hash_ff >> 3));
            end else begin
               hash_next = hash_ff ^ ~((hash_ff << 11) ^ char_ff ^ (hash_ff >> 5));
            end
         end
         default: begin
            hash_next = hash_ff;
         end
      endcase
   end

   // Restoring remainder step: one dividend bit per cycle.
   assign div_shifted = {rem_ff, dividend_ff[HASH_WIDTH-1]};
   assign div_diff    = div_shifted - {1'b0, bucket_ff};

   always_comb begin
      state_in     = state_ff;
      algorithm_in = algorithm_ff;
      bucket_in    = bucket_ff;
      hash_in      = hash_ff;
      rs_mult_in   = rs_mult_ff;
      odd_in       = odd_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      dividend_in  = dividend_ff;
      rem_in       = rem_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_transfer;
      rsp_index_in = rsp_index_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_transfer) begin
               char_in  = {{(HASH_WIDTH-KEY_WIDTH){req_bus.key_byte[KEY_WIDTH-1]}},
                           req_bus.key_byte};
               last_in  = req_bus.last_byte;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = mul_product;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            hash_in = hash_next;
            if (algorithm_ff == ALG_RS) begin
               rs_mult_in = mul_product;
            end
            if (algorithm_ff == ALG_AP) begin
               odd_in = !odd_ff;
            end
            state_in = ST_IDLE;
            if (last_ff) begin
               hash_in     = ssh_seed(algorithm_ff);
               rs_mult_in  = RS_A_SEED;
               odd_in      = 1'b0;
               dividend_in = hash_next;
               rem_in      = hash_next;
               count_in    = '0;
               if (bucket_ff == '0) begin
                  state_in = ST_DELIVER;
               end else begin
                  rem_in   = '0;
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            rem_in      = div_diff[HASH_WIDTH] ? div_shifted[HASH_WIDTH-1:0]
                                               : div_diff[HASH_WIDTH-1:0];
            dividend_in = dividend_ff << 1;
            count_in    = count_ff + 1'b1;
            if (count_ff == DIV_COUNT_WIDTH'(HASH_WIDTH - 1)) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_transfer) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = rem_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The user must write configuration only while the block is idle; the block does not enforce this.
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ALGORITHM: begin
               algorithm_in = csr_write_data[ALG_WIDTH-1:0];
               hash_in      = ssh_seed(csr_write_data[ALG_WIDTH-1:0]);
               rs_mult_in   = RS_A_SEED;
               odd_in       = 1'b0;
            end
            CSR_BUCKET_COUNT: begin
               bucket_in = csr_write_data[HASH_WIDTH-1:0];
            end
            default: begin
               bucket_in = bucket_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         algorithm_ff <= ALG_RS;
         bucket_ff    <= BUCKET_RESET;
         hash_ff      <= ssh_seed(ALG_RS);
         rs_mult_ff   <= RS_A_SEED;
         odd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         algorithm_ff <= algorithm_in;
         bucket_ff    <= bucket_in;
         hash_ff      <= hash_in;
         rs_mult_ff   <= rs_mult_in;
         odd_ff       <= odd_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff      <= char_in;
      last_ff      <= last_in;
      prod_ff      <= prod_in;
      dividend_ff  <= dividend_in;
      rem_ff       <= rem_in;
      rsp_index_ff <= rsp_index_in;
   end

endmodule

`default_nettype wire

@@ src/ssh_checker.sv @@
`default_nettype none

module ssh_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_valid,
   input wire                                req_ready,
   input wire                                rsp_valid,
   input wire                                rsp_ready,
   input wire [ssh_pkg::HASH_WIDTH-1:0]      rsp_bucket_index,
   input wire                                csr_write_enable,
   input wire [ssh_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input wire [ssh_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import ssh_pkg::*;

   logic [HASH_WIDTH-1:0] bucket_ff, bucket_in;

   // Shadow of the bucket count register, as seen on the configuration port.
   always_comb begin
      bucket_in = bucket_ff;
      if (csr_write_enable && (csr_index == CSR_BUCKET_COUNT)) begin
         bucket_in = csr_write_data[HASH_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_ff <= BUCKET_RESET;
      end else begin
         bucket_ff <= bucket_in;
      end
   end

   // A stalled result stays valid and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bucket_index))
      else $error("result changed while stalled");

   // Each byte is worked on in ST_MUL and ST_UPDATE, so the request side closes after it is accepted.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("byte accepted in back-to-back cycles");

   // A reduced result is always below the bucket count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (bucket_ff != '0) |-> rsp_bucket_index < bucket_ff)
      else $error("bucket index not below bucket count");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind selectable_string_hasher ssh_checker u_ssh_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_bucket_index (rsp_bus.bucket_index),
   .csr_write_enable (csr_write_enable),
   .csr_index        (csr_index),
   .csr_write_data   (csr_write_data)
);

`default_nettype wire
